// File: rtl/gqtl_pkg.sv
// Shared types, codes and helpers for the glyph quad text layout block.
`timescale 1ns / 1ps

package gqtl_pkg;

    localparam int unsigned POS_W   = 24;
    localparam int unsigned TEX_W   = 17;
    localparam int unsigned CODE_W  = 7;
    localparam int unsigned LH_W    = 16;
    localparam int unsigned VIDX_W  = 3;

    localparam logic [CODE_W-1:0] CODE_NEWLINE        = 7'd10;
    localparam logic [CODE_W-1:0] CODE_SPACE          = 7'd32;
    localparam logic [CODE_W-1:0] CODE_LAST_PRINTABLE = 7'd126;

    localparam logic [LH_W-1:0]   LINE_HEIGHT_RESET   = 16'd1024;
    localparam logic [VIDX_W-1:0] LAST_VERTEX_IDX     = 3'd5;

    localparam logic signed [POS_W-1:0] POS_MAX = 24'sh7FFFFF;
    localparam logic signed [POS_W-1:0] POS_MIN = 24'sh800000;

    typedef enum logic [1:0] {
        OP_LOAD_GEOM = 2'd0,
        OP_LOAD_TEX  = 2'd1,
        OP_START     = 2'd2,
        OP_CHAR      = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        K_NONE,
        K_START,
        K_NEWLINE,
        K_SPACE,
        K_GLYPH
    } t_kind;

    typedef struct packed {
        logic signed [POS_W-1:0] left;
        logic signed [POS_W-1:0] right;
        logic signed [POS_W-1:0] top;
        logic signed [POS_W-1:0] bottom;
        logic signed [POS_W-1:0] adv;
    } t_geom;

    typedef struct packed {
        logic [TEX_W-1:0] u_left;
        logic [TEX_W-1:0] u_right;
        logic [TEX_W-1:0] v_top;
        logic [TEX_W-1:0] v_bottom;
    } t_tex;

    function automatic logic signed [POS_W-1:0] sat_add(
        input logic signed [POS_W-1:0] a,
        input logic signed [POS_W-1:0] b
    );
        logic signed [POS_W:0] sum;
        sum = {a[POS_W-1], a} + {b[POS_W-1], b};
        if (sum[POS_W] != sum[POS_W-1]) begin
            return sum[POS_W] ? POS_MIN : POS_MAX;
        end
        return sum[POS_W-1:0];
    endfunction

endpackage

// File: rtl/gqtl_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps

module gqtl_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/glyph_quad_text_layout.sv
// Top level: glyph table in RAM, pen tracking and six-vertex quad emission.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+------------------------------------------
//  input    | i_valid / o_ready       | i_opcode, i_code, edges, advance, tex
//  output   | o_valid / i_ready       | o_vertex_x/y/u/v, o_last_vertex
//  config   | i_line_height_we        | i_line_height
//
//  A drawn character is emitted as six vertices, one at a time on the single output port.
//  Loads, start, newline, space and ignored codes emit no vertices.
//  First vertex appears after acceptance via the RAM read register, then the quad register.
//  Reset is synchronous, clears pen and control and sets line height to 1024; no RAM clearing.
//  Output stall holds the quad register, which in turn stalls the next glyph.
`timescale 1ns / 1ps

module glyph_quad_text_layout
    import gqtl_pkg::*;
#(
    parameter int unsigned GLYPH_SLOTS = 95
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_line_height_we,
    input  logic [LH_W-1:0]         i_line_height,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [1:0]              i_opcode,
    input  logic [CODE_W-1:0]       i_code,
    input  logic signed [POS_W-1:0] i_left,
    input  logic signed [POS_W-1:0] i_right,
    input  logic signed [POS_W-1:0] i_top,
    input  logic signed [POS_W-1:0] i_bottom,
    input  logic signed [POS_W-1:0] i_advance,
    input  logic [TEX_W-1:0]        i_tex_u_left,
    input  logic [TEX_W-1:0]        i_tex_u_right,
    input  logic [TEX_W-1:0]        i_tex_v_top,
    input  logic [TEX_W-1:0]        i_tex_v_bottom,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [POS_W-1:0] o_vertex_x,
    output logic signed [POS_W-1:0] o_vertex_y,
    output logic [TEX_W-1:0]        o_vertex_u,
    output logic [TEX_W-1:0]        o_vertex_v,
    output logic                    o_last_vertex
);

    localparam int unsigned SLOT_W = (GLYPH_SLOTS > 1) ? $clog2(GLYPH_SLOTS) : 1;

    logic [LH_W-1:0]         r_line_height;
    t_kind                   r_s1_kind, n_s1_kind;
    logic signed [POS_W-1:0] r_org_x, r_org_y;
    logic signed [POS_W-1:0] r_pen_x, r_pen_y, n_pen_x, n_pen_y;
    logic                    r_q_valid;
    logic [VIDX_W-1:0]       r_q_idx;
    logic signed [POS_W-1:0] r_xl, r_xr, r_yt, r_yb;
    t_tex                    r_q_tex;

    logic                    in_accept, out_accept;
    logic [CODE_W-1:0]       in_slot;
    logic                    in_slot_ok;
    logic                    geom_we, tex_we, rd_en;
    logic                    q_free, s1_stall, s1_fire, q_load;
    t_geom                   wr_geom, rd_geom;
    t_tex                    wr_tex, rd_tex;
    logic signed [POS_W-1:0] lh_s;

    assign in_accept  = i_valid && o_ready;
    assign out_accept = r_q_valid && i_ready;
    assign in_slot    = i_code - CODE_SPACE;
    assign in_slot_ok = (i_code >= CODE_SPACE) && (i_code <= CODE_LAST_PRINTABLE)
                        && ({1'b0, in_slot} < 8'(GLYPH_SLOTS));

    assign geom_we = in_accept && (t_opcode'(i_opcode) == OP_LOAD_GEOM) && in_slot_ok;
    assign tex_we  = in_accept && (t_opcode'(i_opcode) == OP_LOAD_TEX) && in_slot_ok;
    assign rd_en   = in_accept && (t_opcode'(i_opcode) == OP_CHAR) && in_slot_ok;

    assign wr_geom = '{left: i_left, right: i_right, top: i_top,
                       bottom: i_bottom, adv: i_advance};
    assign wr_tex  = '{u_left: i_tex_u_left, u_right: i_tex_u_right,
                       v_top: i_tex_v_top, v_bottom: i_tex_v_bottom};

    gqtl_ram #(
        .WIDTH ($bits(t_geom)),
        .DEPTH (GLYPH_SLOTS)
    ) u_geom_ram (
        .i_clk   (i_clk),
        .i_we    (geom_we),
        .i_waddr (in_slot[SLOT_W-1:0]),
        .i_wdata (wr_geom),
        .i_re    (rd_en),
        .i_raddr (in_slot[SLOT_W-1:0]),
        .o_rdata (rd_geom)
    );

    gqtl_ram #(
        .WIDTH ($bits(t_tex)),
        .DEPTH (GLYPH_SLOTS)
    ) u_tex_ram (
        .i_clk   (i_clk),
        .i_we    (tex_we),
        .i_waddr (in_slot[SLOT_W-1:0]),
        .i_wdata (wr_tex),
        .i_re    (rd_en),
        .i_raddr (in_slot[SLOT_W-1:0]),
        .o_rdata (rd_tex)
    );

    assign q_free   = !r_q_valid || ((r_q_idx == LAST_VERTEX_IDX) && i_ready);
    assign s1_stall = (r_s1_kind == K_GLYPH) && !q_free;
    assign s1_fire  = (r_s1_kind != K_NONE) && !s1_stall;
    assign q_load   = (r_s1_kind == K_GLYPH) && q_free;
    assign o_ready  = !s1_stall;
    assign lh_s     = POS_W'(r_line_height);

    always_comb begin
        n_s1_kind = K_NONE;
        if (in_accept) begin
            unique case (t_opcode'(i_opcode))
                OP_START: n_s1_kind = K_START;
                OP_CHAR: begin
                    if (i_code == CODE_NEWLINE) begin
                        n_s1_kind = K_NEWLINE;
                    end else if (in_slot_ok) begin
                        n_s1_kind = (i_code == CODE_SPACE) ? K_SPACE : K_GLYPH;
                    end
                end
                default: n_s1_kind = K_NONE;
            endcase
        end
    end

    always_comb begin
        n_pen_x = r_pen_x;
        n_pen_y = r_pen_y;
        if (s1_fire) begin
            unique case (r_s1_kind)
                K_START: begin
                    n_pen_x = r_org_x;
                    n_pen_y = sat_add(r_org_y, lh_s);
                end
                K_NEWLINE: begin
                    n_pen_x = '0;
                    n_pen_y = sat_add(r_pen_y, lh_s);
                end
                K_SPACE, K_GLYPH: n_pen_x = sat_add(r_pen_x, rd_geom.adv);
                default: n_pen_x = r_pen_x;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_height <= LINE_HEIGHT_RESET;
            r_s1_kind     <= K_NONE;
            r_pen_x       <= '0;
            r_pen_y       <= '0;
            r_q_valid     <= 1'b0;
            r_q_idx       <= '0;
        end else begin
            if (i_line_height_we) begin
                r_line_height <= i_line_height;
            end
            if (!s1_stall) begin
                r_s1_kind <= n_s1_kind;
            end
            r_pen_x <= n_pen_x;
            r_pen_y <= n_pen_y;
            if (q_load) begin
                r_q_valid <= 1'b1;
                r_q_idx   <= '0;
            end else if (out_accept) begin
                if (r_q_idx == LAST_VERTEX_IDX) begin
                    r_q_valid <= 1'b0;
                end
                r_q_idx <= r_q_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_org_x <= i_left;
            r_org_y <= i_top;
        end
        if (q_load) begin
            r_xl    <= sat_add(r_pen_x, rd_geom.left);
            r_xr    <= sat_add(r_pen_x, rd_geom.right);
            r_yt    <= sat_add(r_pen_y, rd_geom.top);
            r_yb    <= sat_add(r_pen_y, rd_geom.bottom);
            r_q_tex <= rd_tex;
        end
    end

    always_comb begin
        o_vertex_x = r_xl;
        o_vertex_y = r_yt;
        o_vertex_u = r_q_tex.u_left;
        o_vertex_v = r_q_tex.v_top;
        case (r_q_idx)
            3'd1: begin
                o_vertex_x = r_xr;
                o_vertex_u = r_q_tex.u_right;
            end
            3'd2, 3'd4: begin
                o_vertex_x = r_xr;
                o_vertex_y = r_yb;
                o_vertex_u = r_q_tex.u_right;
                o_vertex_v = r_q_tex.v_bottom;
            end
            3'd5: begin
                o_vertex_y = r_yb;
                o_vertex_v = r_q_tex.v_bottom;
            end
            default: o_vertex_x = r_xl;
        endcase
    end

    assign o_valid       = r_q_valid;
    assign o_last_vertex = (r_q_idx == LAST_VERTEX_IDX);

endmodule

// File: rtl/gqtl_checker.sv
// Port-level checks for the glyph quad text layout block, bound to the top level.
`timescale 1ns / 1ps

module gqtl_checker
    import gqtl_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    o_valid,
    input logic                    i_ready,
    input logic signed [POS_W-1:0] o_vertex_x,
    input logic signed [POS_W-1:0] o_vertex_y,
    input logic [TEX_W-1:0]        o_vertex_u,
    input logic [TEX_W-1:0]        o_vertex_v,
    input logic                    o_last_vertex
);

    logic [VIDX_W-1:0] r_cnt, n_cnt;
    logic              out_accept;

    assign out_accept = o_valid && i_ready;

    always_comb begin
        n_cnt = r_cnt;
        if (out_accept) begin
            n_cnt = (r_cnt == LAST_VERTEX_IDX) ? '0 : r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    a_sixth_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_vertex == (r_cnt == LAST_VERTEX_IDX)))
        else $error("last vertex flag not on every sixth vertex");

    a_quad_unbroken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_accept && !o_last_vertex) |=> o_valid)
        else $error("gap inside a quad");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_vertex_x) && $stable(o_vertex_y)
            && $stable(o_vertex_u) && $stable(o_vertex_v) && $stable(o_last_vertex)))
        else $error("stalled vertex transaction changed");

endmodule

bind glyph_quad_text_layout gqtl_checker u_gqtl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_vertex_x    (o_vertex_x),
    .o_vertex_y    (o_vertex_y),
    .o_vertex_u    (o_vertex_u),
    .o_vertex_v    (o_vertex_v),
    .o_last_vertex (o_last_vertex)
);
